### design/csf_pkg.sv
// Shared types, widths and saturation helpers for the contact spring force core.
// No dependencies; imported by every module of the block.
package csf_pkg;

    localparam int MAX_CONTACTS_DEF        = 1024;
    localparam int SPRINGS_PER_CONTACT_DEF = 2;

    localparam int CONTACT_W = 10;
    localparam int DISP_W    = 32;
    localparam int ROT_W     = 16;
    localparam int STIFF_W   = 32;
    localparam int FORCE_W   = 48;

    // s_axis tdata: contact, slot, d1x, d1z, d2x, d2z, ra, rb, rc, rd, ks, kn -> 267 bits
    localparam int IN_RAW_W    = CONTACT_W + 1 + 4 * DISP_W + 4 * ROT_W + 2 * STIFF_W;
    localparam int IN_TDATA_W  = ((IN_RAW_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 6 * FORCE_W;

    localparam logic signed [FORCE_W-1:0] F48_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
    localparam logic signed [FORCE_W-1:0] F48_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

    // one enable per datapath step, driven by the sequencer
    typedef struct packed {
        logic load;
        logic loc;
        logic lrnd;
        logic inc;
        logic rinc;
        logic acc;
        logic gmul;
        logic grnd;
    } t_csf_step;

    function automatic logic signed [DISP_W-1:0] sat32(input logic signed [35:0] v);
        logic hi_ok;
        logic lo_ok;
        hi_ok = (v <= 36'sh0_7FFF_FFFF);
        lo_ok = (v >= -36'sh0_8000_0000);
        if (!hi_ok) begin
            return {1'b0, {(DISP_W-1){1'b1}}};
        end else if (!lo_ok) begin
            return {1'b1, {(DISP_W-1){1'b0}}};
        end
        return v[DISP_W-1:0];
    endfunction

    function automatic logic signed [FORCE_W-1:0] sat48(input logic signed [50:0] v);
        logic all0;
        logic all1;
        // in range when the top bits are all copies of bit 47
        all0 = (v[50:47] == 4'b0000);
        all1 = (v[50:47] == 4'b1111);
        if (all0 || all1) begin
            return v[FORCE_W-1:0];
        end else if (v[50]) begin
            return F48_MIN;
        end
        return F48_MAX;
    endfunction

endpackage

### design/csf_force_mem.sv
// Force store: shear and normal local force per spring, one shared port.
// Synchronous, registered read. Depends on csf_pkg.
module csf_force_mem #(
    parameter int DEPTH = csf_pkg::MAX_CONTACTS_DEF * csf_pkg::SPRINGS_PER_CONTACT_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic                                i_we,
    input  logic [AW-1:0]                       i_addr,
    input  logic signed [csf_pkg::FORCE_W-1:0]  i_wdata_shear,
    input  logic signed [csf_pkg::FORCE_W-1:0]  i_wdata_normal,
    output logic signed [csf_pkg::FORCE_W-1:0]  o_rdata_shear,
    output logic signed [csf_pkg::FORCE_W-1:0]  o_rdata_normal
);
    import csf_pkg::*;

    logic signed [FORCE_W-1:0] r_shear_mem  [DEPTH];
    logic signed [FORCE_W-1:0] r_normal_mem [DEPTH];
    logic signed [FORCE_W-1:0] r_rd_shear;
    logic signed [FORCE_W-1:0] r_rd_normal;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_shear_mem[i_addr]  <= i_wdata_shear;
                r_normal_mem[i_addr] <= i_wdata_normal;
            end else begin
                r_rd_shear  <= r_shear_mem[i_addr];
                r_rd_normal <= r_normal_mem[i_addr];
            end
        end
    end

    assign o_rdata_shear  = r_rd_shear;
    assign o_rdata_normal = r_rd_normal;

endmodule

### design/csf_datapath.sv
// Arithmetic steps: rotate to local axes, scale by stiffness, accumulate
// with the stored force, rotate back. One register per step. Depends on csf_pkg.
module csf_datapath (
    input  logic                                i_clk,
    input  csf_pkg::t_csf_step                  i_step,
    input  logic signed [csf_pkg::DISP_W-1:0]   i_disp_one_x,
    input  logic signed [csf_pkg::DISP_W-1:0]   i_disp_one_z,
    input  logic signed [csf_pkg::DISP_W-1:0]   i_disp_two_x,
    input  logic signed [csf_pkg::DISP_W-1:0]   i_disp_two_z,
    input  logic signed [csf_pkg::ROT_W-1:0]    i_rot_a,
    input  logic signed [csf_pkg::ROT_W-1:0]    i_rot_b,
    input  logic signed [csf_pkg::ROT_W-1:0]    i_rot_c,
    input  logic signed [csf_pkg::ROT_W-1:0]    i_rot_d,
    input  logic [csf_pkg::STIFF_W-1:0]         i_shear_stiffness,
    input  logic [csf_pkg::STIFF_W-1:0]         i_normal_stiffness,
    input  logic signed [csf_pkg::FORCE_W-1:0]  i_store_shear,
    input  logic signed [csf_pkg::FORCE_W-1:0]  i_store_normal,
    output logic signed [csf_pkg::FORCE_W-1:0]  o_force_shear,
    output logic signed [csf_pkg::FORCE_W-1:0]  o_force_normal,
    output logic signed [csf_pkg::FORCE_W-1:0]  o_global_x,
    output logic signed [csf_pkg::FORCE_W-1:0]  o_global_z
);
    import csf_pkg::*;

    logic signed [ROT_W-1:0]   r_ra, r_rb, r_rc, r_rd;
    logic [STIFF_W-1:0]        r_ks, r_kn;
    logic signed [DISP_W:0]    r_cx, r_cz;
    logic signed [48:0]        r_p0, r_p1, r_p2, r_p3;
    logic signed [DISP_W-1:0]  r_ls, r_ln;
    logic signed [64:0]        r_ps, r_pn;
    logic signed [FORCE_W-1:0] r_is, r_in;
    logic signed [FORCE_W-1:0] r_fs, r_fn;
    logic signed [63:0]        r_q0, r_q1, r_q2, r_q3;
    logic signed [FORCE_W-1:0] r_gx, r_gz;

    logic signed [49:0] n_sum_s, n_sum_n;
    logic signed [64:0] n_rnd_s, n_rnd_n;
    logic signed [48:0] n_acc_s, n_acc_n;
    logic signed [64:0] n_gsum_x, n_gsum_z;

    // Q.30 sums rounded half up to Q16.16
    assign n_sum_s = {r_p0[48], r_p0} + {r_p1[48], r_p1} + 50'sd8192;
    assign n_sum_n = {r_p2[48], r_p2} + {r_p3[48], r_p3} + 50'sd8192;
    // Q.32 product fits 64 bits, so the half can be added without overflow
    assign n_rnd_s = r_ps + 65'sd32768;
    assign n_rnd_n = r_pn + 65'sd32768;
    assign n_acc_s = {i_store_shear[FORCE_W-1], i_store_shear} + {r_is[FORCE_W-1], r_is};
    assign n_acc_n = {i_store_normal[FORCE_W-1], i_store_normal} + {r_in[FORCE_W-1], r_in};
    assign n_gsum_x = {r_q0[63], r_q0} + {r_q1[63], r_q1} + 65'sd8192;
    assign n_gsum_z = {r_q2[63], r_q2} + {r_q3[63], r_q3} + 65'sd8192;

    always_ff @(posedge i_clk) begin
        if (i_step.load) begin
            r_cx <= {i_disp_one_x[DISP_W-1], i_disp_one_x} - {i_disp_two_x[DISP_W-1], i_disp_two_x};
            r_cz <= {i_disp_one_z[DISP_W-1], i_disp_one_z} - {i_disp_two_z[DISP_W-1], i_disp_two_z};
            r_ra <= i_rot_a;
            r_rb <= i_rot_b;
            r_rc <= i_rot_c;
            r_rd <= i_rot_d;
            r_ks <= i_shear_stiffness;
            r_kn <= i_normal_stiffness;
        end
        if (i_step.loc) begin
            r_p0 <= r_ra * r_cx;
            r_p1 <= r_rb * r_cz;
            r_p2 <= r_rc * r_cx;
            r_p3 <= r_rd * r_cz;
        end
        if (i_step.lrnd) begin
            r_ls <= sat32(n_sum_s[49:14]);
            r_ln <= sat32(n_sum_n[49:14]);
        end
        if (i_step.inc) begin
            r_ps <= r_ls * $signed({1'b0, r_ks});
            r_pn <= r_ln * $signed({1'b0, r_kn});
        end
        if (i_step.rinc) begin
            r_is <= n_rnd_s[63:16];
            r_in <= n_rnd_n[63:16];
        end
        if (i_step.acc) begin
            r_fs <= sat48({{2{n_acc_s[48]}}, n_acc_s});
            r_fn <= sat48({{2{n_acc_n[48]}}, n_acc_n});
        end
        if (i_step.gmul) begin
            r_q0 <= r_ra * r_fs;
            r_q1 <= r_rc * r_fn;
            r_q2 <= r_rb * r_fs;
            r_q3 <= r_rd * r_fn;
        end
        if (i_step.grnd) begin
            r_gx <= sat48(n_gsum_x[64:14]);
            r_gz <= sat48(n_gsum_z[64:14]);
        end
    end

    assign o_force_shear  = r_fs;
    assign o_force_normal = r_fn;
    assign o_global_x     = r_gx;
    assign o_global_z     = r_gz;

endmodule

### design/contact_spring_force_update_core.sv
// Top level of the contact spring force core: stream ports, sequencer,
// force store clearing and output register. Depends on csf_pkg, csf_force_mem, csf_datapath.
//
// Usage:
//   s_axis carries one spring update request per beat (contact, slot, node
//   displacements, local frame, stiffnesses). m_axis returns one result per
//   in-range request: new local shear/normal force and the global force on
//   both sides. Requests with contact >= MAX_CONTACTS or slot >=
//   SPRINGS_PER_CONTACT are taken and dropped without touching the store.
//   Sequencing: the sequencer walks each in-range request through seven arithmetic
//   steps (store read in the first, write-back in the sixth) and the output load,
//   then returns to idle to take the next; a new request is not taken until the
//   previous one has been loaded into the output register.
//   Reset: a clearing pass writes zero to every store entry, one entry per
//   cycle (MAX_CONTACTS * SPRINGS_PER_CONTACT entries, 2048 by default);
//   s_axis_tready stays low until it finishes.
//   Stall: the result sits in the output register while m_axis_tready is low;
//   the next request is still taken and runs up to its last step, then waits.
module contact_spring_force_update_core #(
    parameter int MAX_CONTACTS        = csf_pkg::MAX_CONTACTS_DEF,
    parameter int SPRINGS_PER_CONTACT = csf_pkg::SPRINGS_PER_CONTACT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // from bit 0: contact_index, spring_slot, disp_one_x, disp_one_z, disp_two_x,
    // disp_two_z, rot_a, rot_b, rot_c, rot_d, shear_stiffness, normal_stiffness, zero pad
    input  logic [csf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // from bit 0: local_shear_force, local_normal_force, side_two_force_x,
    // side_two_force_z, side_one_force_x, side_one_force_z
    output logic [csf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import csf_pkg::*;

    localparam int DEPTH = MAX_CONTACTS * SPRINGS_PER_CONTACT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_LOC   = 4'd2;
    localparam logic [3:0] ST_LRND  = 4'd3;
    localparam logic [3:0] ST_INC   = 4'd4;
    localparam logic [3:0] ST_RINC  = 4'd5;
    localparam logic [3:0] ST_ACC   = 4'd6;
    localparam logic [3:0] ST_GMUL  = 4'd7;
    localparam logic [3:0] ST_GRND  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_clr_addr, n_clr_addr;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [CONTACT_W-1:0]      w_contact;
    logic                      w_slot;
    logic                      w_in_range;
    logic                      w_take;
    logic                      w_out_load;
    t_csf_step                 w_step;

    logic                      w_mem_en, w_mem_we;
    logic [AW-1:0]             w_mem_addr;
    logic signed [FORCE_W-1:0] w_mem_wd_s, w_mem_wd_n;
    logic signed [FORCE_W-1:0] w_store_s, w_store_n;
    logic signed [FORCE_W-1:0] w_fs, w_fn, w_gx, w_gz, w_nx, w_nz;

    assign w_contact = s_axis_tdata[CONTACT_W-1:0];
    assign w_slot    = s_axis_tdata[CONTACT_W];
    assign w_in_range = (32'(w_contact) < 32'(MAX_CONTACTS)) &&
                        (32'(w_slot) < 32'(SPRINGS_PER_CONTACT));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == ST_OUT) && (!r_out_valid || m_axis_tready);

    always_comb begin
        w_step      = '0;
        w_step.load = w_take;
        w_step.loc  = (r_state == ST_LOC);
        w_step.lrnd = (r_state == ST_LRND);
        w_step.inc  = (r_state == ST_INC);
        w_step.rinc = (r_state == ST_RINC);
        w_step.acc  = (r_state == ST_ACC);
        w_step.gmul = (r_state == ST_GMUL);
        w_step.grnd = (r_state == ST_GRND);
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_addr     = r_addr;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_take && w_in_range) begin
                    n_addr  = AW'(32'(w_contact) * 32'(SPRINGS_PER_CONTACT) + 32'(w_slot));
                    n_state = ST_LOC;
                end
            end
            ST_LOC:  n_state = ST_LRND;
            ST_LRND: n_state = ST_INC;
            ST_INC:  n_state = ST_RINC;
            ST_RINC: n_state = ST_ACC;
            ST_ACC:  n_state = ST_GMUL;
            ST_GMUL: n_state = ST_GRND;
            ST_GRND: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        if (w_out_load) begin
            r_out_data <= {w_nz, w_nx, w_gz, w_gx, w_fn, w_fs};
        end
    end

    // store port: clear sweep, read at the start of a request, write-back after accumulate
    always_comb begin
        w_mem_en   = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_addr = r_addr;
        w_mem_wd_s = w_fs;
        w_mem_wd_n = w_fn;
        if (r_state == ST_CLEAR) begin
            w_mem_en   = 1'b1;
            w_mem_we   = 1'b1;
            w_mem_addr = r_clr_addr;
            w_mem_wd_s = '0;
            w_mem_wd_n = '0;
        end else if (r_state == ST_LOC) begin
            w_mem_en = 1'b1;
        end else if (r_state == ST_GMUL) begin
            w_mem_en = 1'b1;
            w_mem_we = 1'b1;
        end
    end

    csf_force_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk          (i_clk),
        .i_en           (w_mem_en),
        .i_we           (w_mem_we),
        .i_addr         (w_mem_addr),
        .i_wdata_shear  (w_mem_wd_s),
        .i_wdata_normal (w_mem_wd_n),
        .o_rdata_shear  (w_store_s),
        .o_rdata_normal (w_store_n)
    );

    csf_datapath u_dp (
        .i_clk              (i_clk),
        .i_step             (w_step),
        .i_disp_one_x       (s_axis_tdata[42:11]),
        .i_disp_one_z       (s_axis_tdata[74:43]),
        .i_disp_two_x       (s_axis_tdata[106:75]),
        .i_disp_two_z       (s_axis_tdata[138:107]),
        .i_rot_a            (s_axis_tdata[154:139]),
        .i_rot_b            (s_axis_tdata[170:155]),
        .i_rot_c            (s_axis_tdata[186:171]),
        .i_rot_d            (s_axis_tdata[202:187]),
        .i_shear_stiffness  (s_axis_tdata[234:203]),
        .i_normal_stiffness (s_axis_tdata[266:235]),
        .i_store_shear      (w_store_s),
        .i_store_normal     (w_store_n),
        .o_force_shear      (w_fs),
        .o_force_normal     (w_fn),
        .o_global_x         (w_gx),
        .o_global_z         (w_gz)
    );

    // negation saturates only at the most negative value
    assign w_nx = (w_gx == F48_MIN) ? F48_MAX : -w_gx;
    assign w_nz = (w_gz == F48_MIN) ? F48_MAX : -w_gz;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### verif/csf_force_checker.sv
// Checker for the contact spring force core: watches both stream channels, predicts
// every result from the accepted requests and compares field by field.
// Depends on csf_pkg for widths and the stream layout.
module csf_force_checker #(
    parameter int MAX_CONTACTS        = csf_pkg::MAX_CONTACTS_DEF,
    parameter int SPRINGS_PER_CONTACT = csf_pkg::SPRINGS_PER_CONTACT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [csf_pkg::IN_TDATA_W-1:0]  i_req_data,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [csf_pkg::OUT_TDATA_W-1:0] i_res_data,
    output int                              o_mismatches,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import csf_pkg::*;

    localparam int STORE_DEPTH = MAX_CONTACTS * SPRINGS_PER_CONTACT;
    localparam int PAD_W       = IN_TDATA_W - IN_RAW_W;

    typedef logic signed [127:0]        t_wide;
    typedef logic signed [FORCE_W-1:0]  t_force;
    typedef logic [OUT_TDATA_W-1:0]     t_force_set;

    // tdata layout, highest field first
    typedef struct packed {
        logic [PAD_W-1:0]          pad;
        logic [STIFF_W-1:0]        normal_stiffness;
        logic [STIFF_W-1:0]        shear_stiffness;
        logic signed [ROT_W-1:0]   rot_d;
        logic signed [ROT_W-1:0]   rot_c;
        logic signed [ROT_W-1:0]   rot_b;
        logic signed [ROT_W-1:0]   rot_a;
        logic signed [DISP_W-1:0]  disp_two_z;
        logic signed [DISP_W-1:0]  disp_two_x;
        logic signed [DISP_W-1:0]  disp_one_z;
        logic signed [DISP_W-1:0]  disp_one_x;
        logic                      spring_slot;
        logic [CONTACT_W-1:0]      contact_index;
    } t_spring_req;

    t_force     shear_store  [STORE_DEPTH];
    t_force     normal_store [STORE_DEPTH];
    t_force_set expected_forces [$];
    int         error_count = 0;
    string      field_names [6] = '{"local_shear_force", "local_normal_force",
                                    "side_two_force_x", "side_two_force_z",
                                    "side_one_force_x", "side_one_force_z"};

    initial begin
        foreach (shear_store[i]) begin
            shear_store[i]  = '0;
            normal_store[i] = '0;
        end
    end

    // round half up, then floor shift
    function automatic t_wide round_shift(input t_wide v, input int n);
        return (v + (t_wide'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic t_wide clamp(input t_wide v, input int w);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    task automatic apply_spring_update(input t_spring_req r);
        t_wide cx, cz, ra, rb, rc, rd, ks, kn;
        t_wide ls, ln, fs, fn, gx, gz, nx, nz;
        int    idx;
        // out-of-range requests are dropped without touching the store
        if (int'(r.contact_index) >= MAX_CONTACTS ||
            int'(r.spring_slot) >= SPRINGS_PER_CONTACT) begin
            return;
        end
        idx = int'(r.contact_index) * SPRINGS_PER_CONTACT + int'(r.spring_slot);

        cx = $signed(r.disp_one_x);
        cx = cx - $signed(r.disp_two_x);
        cz = $signed(r.disp_one_z);
        cz = cz - $signed(r.disp_two_z);
        ra = $signed(r.rot_a);
        rb = $signed(r.rot_b);
        rc = $signed(r.rot_c);
        rd = $signed(r.rot_d);
        ks = {1'b0, r.shear_stiffness};
        kn = {1'b0, r.normal_stiffness};

        ls = clamp(round_shift(ra * cx + rb * cz, 14), DISP_W);
        ln = clamp(round_shift(rc * cx + rd * cz, 14), DISP_W);

        fs = shear_store[idx];
        fn = normal_store[idx];
        fs = clamp(fs + round_shift(ls * ks, 16), FORCE_W);
        fn = clamp(fn + round_shift(ln * kn, 16), FORCE_W);
        shear_store[idx]  = fs[FORCE_W-1:0];
        normal_store[idx] = fn[FORCE_W-1:0];

        // back to global axes with the transposed frame
        gx = clamp(round_shift(ra * fs + rc * fn, 14), FORCE_W);
        gz = clamp(round_shift(rb * fs + rd * fn, 14), FORCE_W);
        nx = clamp(-gx, FORCE_W);
        nz = clamp(-gz, FORCE_W);

        expected_forces.push_back({nz[FORCE_W-1:0], nx[FORCE_W-1:0], gz[FORCE_W-1:0],
                                   gx[FORCE_W-1:0], fn[FORCE_W-1:0], fs[FORCE_W-1:0]});
    endtask

    always @(posedge i_clk) begin
        t_force_set want;
        t_force     want_f;
        t_force     got_f;
        int         k;
        if (i_rst_n) begin
            // result side first: a result never belongs to a request taken at the same edge
            if (i_res_valid && i_res_ready) begin
                if (expected_forces.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("unexpected result %h", i_res_data);
                    end
                end else begin
                    want = expected_forces.pop_front();
                    for (k = 0; k < 6; k++) begin
                        want_f = want[k*FORCE_W +: FORCE_W];
                        got_f  = i_res_data[k*FORCE_W +: FORCE_W];
                        if (got_f !== want_f) begin
                            error_count++;
                            if (error_count <= 10) begin
                                $display("mismatch %s: expected %0d, got %0d",
                                         field_names[k], want_f, got_f);
                            end
                        end
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                apply_spring_update(i_req_data);
            end
        end
        o_mismatches <= error_count;
        o_pending    <= expected_forces.size();
    end

endmodule

### verif/tb.sv
// Testbench top for the contact spring force core: clock, reset, request stimulus
// with idle and stall phases, and the final verdict.
// Depends on csf_pkg, contact_spring_force_update_core and csf_force_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import csf_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int PAD_W       = IN_TDATA_W - IN_RAW_W;

    localparam logic [DISP_W-1:0]  D_MAX = 32'h7FFF_FFFF;
    localparam logic [DISP_W-1:0]  D_MIN = 32'h8000_0000;
    localparam logic [ROT_W-1:0]   R_ONE = 16'h4000;
    localparam logic [ROT_W-1:0]   R_MAX = 16'h7FFF;
    localparam logic [ROT_W-1:0]   R_MIN = 16'h8000;
    localparam logic [STIFF_W-1:0] K_ONE = 32'h0001_0000;
    localparam logic [STIFF_W-1:0] K_MAX = 32'hFFFF_FFFF;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatches;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    int idle_tab [4]  = '{0, 81, 0, 13};
    int stall_tab [4] = '{0, 0, 81, 13};

    always #4 i_clk = ~i_clk;

    contact_spring_force_update_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    csf_force_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_spring(
        input logic [CONTACT_W-1:0] contact,
        input logic                 slot,
        input logic [DISP_W-1:0]    d1x, d1z, d2x, d2z,
        input logic [ROT_W-1:0]     ra, rb, rc, rd,
        input logic [STIFF_W-1:0]   ks, kn
    );
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{PAD_W{1'b0}}, kn, ks, rd, rc, rb, ra, d2z, d2x, d1z, d1x,
                          slot, contact};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [DISP_W-1:0] pick_disp();
        int v;
        if ($urandom_range(0, 4) == 0) begin
            return $urandom;
        end
        v = int'($urandom_range(0, 262144)) - 131072;
        return v;
    endfunction

    function automatic logic [ROT_W-1:0] pick_rot();
        int v;
        if ($urandom_range(0, 4) == 0) begin
            return ROT_W'($urandom);
        end
        v = int'($urandom_range(0, 32768)) - 16384;
        return v[ROT_W-1:0];
    endfunction

    function automatic logic [STIFF_W-1:0] pick_stiff();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        return $urandom_range(0, 32'h0010_0000);
    endfunction

    // mostly a few hot springs so forces build up, with hits on the same entry back to back
    task automatic send_random_spring();
        logic [CONTACT_W-1:0] contact;
        if ($urandom_range(0, 3) == 0) begin
            contact = CONTACT_W'($urandom_range(0, 1023));
        end else begin
            contact = CONTACT_W'($urandom_range(0, 7));
        end
        send_spring(contact, 1'($urandom_range(0, 1)), pick_disp(), pick_disp(), pick_disp(),
                    pick_disp(), pick_rot(), pick_rot(), pick_rot(), pick_rot(),
                    pick_stiff(), pick_stiff());
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all zero, then the far corner of the store with an identity frame
        send_spring(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_spring(1023, 1, 32'h0001_0000, 0, 0, 32'h0002_0000,
                    R_ONE, 0, 0, R_ONE, K_ONE, K_ONE);
        send_spring(1023, 1, 32'hFFFF_8000, 32'h0001_8000, 0, 0,
                    16'h2D41, 16'hD2BF, 16'h2D41, 16'h2D41, K_ONE, 32'h0002_8000);
        // exact halves round up on both signs
        send_spring(1, 0, 1, 0, 0, 0, 16'h2000, 0, 0, 16'h2000, 32'h8000, 32'h8000);
        send_spring(1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0,
                    16'h2000, 0, 0, 16'h2000, 32'h8000, 32'h8000);
        // local displacement saturates low, force store driven to its minimum
        repeat (3) begin
            send_spring(2, 0, D_MAX, D_MAX, D_MIN, D_MIN, R_MIN, R_MIN, R_MIN, R_MIN,
                        K_MAX, K_MAX);
        end
        // store driven to its maximum, then a -2 frame makes the negation saturate
        repeat (2) begin
            send_spring(2, 1, D_MAX, D_MAX, D_MIN, D_MIN, R_MAX, 0, 0, R_MAX,
                        K_MAX, K_MAX);
        end
        send_spring(2, 1, 0, 0, 0, 0, R_MIN, 0, 0, R_MIN, 0, 0);
        send_spring(10'h3FF, 1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1);
        send_spring(0, 0, D_MIN, D_MIN, D_MAX, D_MAX, R_MIN, R_MIN, R_MIN, R_MIN,
                    K_MAX, K_MAX);
        send_spring(3, 0, D_MAX, D_MIN, 0, 0, R_ONE, R_ONE, R_MIN, R_MAX, 0, 0);
        send_spring(10'h2AA, 0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                    16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 32'hAAAA_AAAA, 32'h5555_5555);
        send_spring(10'h155, 1, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                    16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 32'h5555_5555, 32'hAAAA_AAAA);

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_tab[p];
            stall_pct <= stall_tab[p];
            repeat (108) send_random_spring();
        end
        s_axis_tvalid <= 1'b0;

        // let the last request reach the checker before waiting for the drain
        repeat (20) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
